@@ sv/tcpq_pkg.sv @@
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared request codes and the command and status words that pass between
// the queue controller and its datapath.
// ----------------------------------------------------------------------------
package tcpq_pkg;

   // request kinds
   localparam logic [1:0] KIND_INSERT   = 2'd0;
   localparam logic [1:0] KIND_SERVE    = 2'd1;
   localparam logic [1:0] KIND_WITHDRAW = 2'd2;
   localparam logic [1:0] KIND_QUERY    = 2'd3;

   // slot memory read address select
   typedef logic [1:0] rd_sel_type;
   localparam rd_sel_type RD_CUR  = 2'd0;
   localparam rd_sel_type RD_NEXT = 2'd1;
   localparam rd_sel_type RD_PREV = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      logic       wr_req;
      logic       idx_inc;
      logic       idx_dec;
      logic       record_hit;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] kind;
      logic       at_end;
      logic       hit;
      logic       full;
      logic       last;
      logic       at_pos;
      logic       out_free;
   } status_type;

endpackage

@@ sv/tcpq_datapath.sv @@
// ----------------------------------------------------------------------------
// tcpq_datapath
// Slot memory, scan index, entry counters, request capture and the
// registered result word.
// ----------------------------------------------------------------------------
module tcpq_datapath #(
   parameter int CAPACITY = 32,
   parameter int ID_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tcpq_pkg::cmd_type                 cmd,
   output tcpq_pkg::status_type              status,
   input  logic [1:0]                        req_kind,
   input  logic [ID_BITS-1:0]                req_person_id,
   input  logic                              req_preferred,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_ok,
   output logic [ID_BITS-1:0]                rsp_served_id,
   output logic                              rsp_found_preferred,
   output logic [$clog2(CAPACITY+1)-1:0]     rsp_occupancy
);
   import tcpq_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

   // slot memory: preferred flag above the id
   logic [ID_BITS:0]    mem [CAPACITY];

   logic [1:0]          kind_ff;
   logic [ID_BITS-1:0]  id_ff;
   logic                pref_ff;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    pcount_ff, pcount_in;
   logic                ok_ff, ok_in;
   logic [ID_BITS-1:0]  served_ff, served_in;
   logic                fpref_ff, fpref_in;
   logic [ID_BITS-1:0]  rd_id_ff;
   logic                rd_pref_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff;
   logic [ID_BITS-1:0]  rsp_served_ff;
   logic                rsp_fpref_ff;
   logic [CNT_W-1:0]    rsp_occ_ff;

   logic [CNT_W-1:0]    rd_idx;
   logic [CNT_W-1:0]    ins_pos;
   logic [ID_BITS:0]    wr_data;

   // read address select
   always_comb begin
      unique case (cmd.rd_sel)
         RD_CUR:  rd_idx = idx_ff;
         RD_NEXT: rd_idx = idx_ff + ONE;
         RD_PREV: rd_idx = idx_ff - ONE;
         default: rd_idx = idx_ff;
      endcase
   end

   assign wr_data = cmd.wr_req ? {pref_ff, id_ff} : {rd_pref_ff, rd_id_ff};

   // slot memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[idx_ff[ADDR_W-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         {rd_pref_ff, rd_id_ff} <= mem[rd_idx[ADDR_W-1:0]];
      end
   end

   // insert position: behind the last preferential entry or at the tail
   assign ins_pos = pref_ff ? pcount_ff : count_ff;

   // status back to the controller
   always_comb begin
      status.kind     = kind_ff;
      status.at_end   = (idx_ff == count_ff);
      status.hit      = (kind_ff == KIND_SERVE) || (rd_id_ff == id_ff);
      status.full     = (count_ff == CAP_CNT);
      status.last     = ((idx_ff + ONE) == count_ff);
      status.at_pos   = (idx_ff == ins_pos);
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   // index, counters and result flags
   always_comb begin
      idx_in    = idx_ff;
      count_in  = count_ff;
      pcount_in = pcount_ff;
      ok_in     = ok_ff;
      served_in = served_ff;
      fpref_in  = fpref_ff;
      if (cmd.load_req) begin
         idx_in    = '0;
         ok_in     = 1'b0;
         served_in = '0;
         fpref_in  = 1'b0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + ONE;
      end
      if (cmd.idx_dec) begin
         idx_in = idx_ff - ONE;
      end
      if (cmd.record_hit) begin
         ok_in = 1'b1;
         if (kind_ff == KIND_SERVE) begin
            served_in = rd_id_ff;
         end
         if (kind_ff == KIND_QUERY) begin
            fpref_in = rd_pref_ff;
         end else if (rd_pref_ff) begin
            pcount_in = pcount_ff - ONE;
         end
      end
      if (cmd.cnt_inc) begin
         ok_in    = 1'b1;
         count_in = count_ff + ONE;
         if (pref_ff) begin
            pcount_in = pcount_ff + ONE;
         end
      end
      if (cmd.cnt_dec) begin
         count_in = count_ff - ONE;
      end
   end

   // result word valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pcount_ff    <= pcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      ok_ff     <= ok_in;
      served_ff <= served_in;
      fpref_ff  <= fpref_in;
      if (cmd.load_req) begin
         kind_ff <= req_kind;
         id_ff   <= req_person_id;
         pref_ff <= req_preferred;
      end
      if (cmd.emit) begin
         rsp_ok_ff     <= ok_ff;
         rsp_served_ff <= served_ff;
         rsp_fpref_ff  <= fpref_ff;
         rsp_occ_ff    <= count_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ok              = rsp_ok_ff;
   assign rsp_served_id       = rsp_served_ff;
   assign rsp_found_preferred = rsp_fpref_ff;
   assign rsp_occupancy       = rsp_occ_ff;

endmodule

@@ sv/tcpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Request sequencer: scans the slots for a match, then shifts entries to
// open or close a gap, and hands the finished word to the output register.
// ----------------------------------------------------------------------------
module tcpq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tcpq_pkg::status_type  status,
   output tcpq_pkg::cmd_type     cmd
);
   import tcpq_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SRCH_RD  = 3'd1;
   localparam logic [2:0] S_SRCH_CMP = 3'd2;
   localparam logic [2:0] S_RM_RD    = 3'd3;
   localparam logic [2:0] S_RM_WR    = 3'd4;
   localparam logic [2:0] S_INS_RD   = 3'd5;
   localparam logic [2:0] S_INS_WR   = 3'd6;
   localparam logic [2:0] S_FINISH   = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            priority if (status.kind == KIND_INSERT && status.full) begin
               state_in = S_FINISH;
            end else if (status.at_end) begin
               state_in = (status.kind == KIND_INSERT) ? S_INS_RD : S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_CUR;
               state_in   = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            priority if (!status.hit) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SRCH_RD;
            end else if (status.kind == KIND_INSERT) begin
               // duplicate id
               state_in = S_FINISH;
            end else if (status.kind == KIND_QUERY) begin
               cmd.record_hit = 1'b1;
               state_in       = S_FINISH;
            end else begin
               cmd.record_hit = 1'b1;
               state_in       = S_RM_RD;
            end
         end
         // close the gap: slot i takes slot i+1
         S_RM_RD: begin
            if (status.last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
               state_in   = S_RM_WR;
            end
         end
         S_RM_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = S_RM_RD;
         end
         // open a gap: slot i takes slot i-1 down to the insert position
         S_INS_RD: begin
            if (status.at_pos) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_req  = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PREV;
               state_in   = S_INS_WR;
            end
         end
         S_INS_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_dec = 1'b1;
            state_in    = S_INS_RD;
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/two_class_priority_queue_unit.sv @@
// Two-class queue of unique ids, preferential entries ahead of ordinary ones.
// Request channel (req_*): kind is insert, serve head, withdraw or query,
// with an id and, for insert, its class. Result channel (rsp_*): one word
// per request with ok, the served id, the class of a queried id and the
// occupancy after the request.
// Entries sit in order in a slot memory with one write port and a
// registered read; every memory step is a read followed by a compare or a
// write. A request scans from the head until a match or the tail (an insert
// into a full queue skips the scan), then a withdraw or serve shifts the
// later entries up and an insert shifts entries down to its position. The
// shortest requests are an insert into a full queue and a serve of an empty
// queue; the longest is an insert at the head of a nearly full queue. One
// request is in flight at a time; the next is taken in the cycle after the
// result word is loaded into the output register.
// A finished word waits in the output register; the next request is taken
// while it waits, and the sequencer holds its last step if the receiver
// still stalls. Reset empties the queue and drops any pending word; the slot
// memory keeps its contents and needs no clearing.
// ----------------------------------------------------------------------------
// two_class_priority_queue_unit
// Top level: sequencer plus slot datapath.
// ----------------------------------------------------------------------------
module two_class_priority_queue_unit #(
   parameter int CAPACITY = 32,
   parameter int ID_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_kind,
   input  logic [ID_BITS-1:0]                req_person_id,
   input  logic                              req_preferred,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_ok,
   output logic [ID_BITS-1:0]                rsp_served_id,
   output logic                              rsp_found_preferred,
   output logic [$clog2(CAPACITY+1)-1:0]     rsp_occupancy
);
   import tcpq_pkg::*;

   cmd_type    cmd;
   status_type status;

   tcpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcpq_datapath #(
      .CAPACITY (CAPACITY),
      .ID_BITS  (ID_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_kind            (req_kind),
      .req_person_id       (req_person_id),
      .req_preferred       (req_preferred),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_ok              (rsp_ok),
      .rsp_served_id       (rsp_served_id),
      .rsp_found_preferred (rsp_found_preferred),
      .rsp_occupancy       (rsp_occupancy)
   );

endmodule

@@ sv/tcpq_checker.sv @@
// ----------------------------------------------------------------------------
// tcpq_checker
// Port-level checks on the queue's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tcpq_checker #(
   parameter int CAPACITY = 32,
   parameter int ID_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_ok,
   input  logic [ID_BITS-1:0]                rsp_served_id,
   input  logic                              rsp_found_preferred,
   input  logic [$clog2(CAPACITY+1)-1:0]     rsp_occupancy
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok)
         && $stable(rsp_served_id) && $stable(rsp_found_preferred)
         && $stable(rsp_occupancy))
      else $error("result word changed while stalled");

   // reset drops any pending word
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a nonzero served id only comes with success
   a_served_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_served_id != '0) |-> rsp_ok)
      else $error("served id on a failed request");

   // a class report only comes with a found id
   a_fpref_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found_preferred |-> rsp_ok && (rsp_served_id == '0))
      else $error("class reported without a hit");

   // occupancy never exceeds capacity
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= CAP_CNT)
      else $error("occupancy beyond capacity");

endmodule

bind two_class_priority_queue_unit tcpq_checker #(
   .CAPACITY (CAPACITY),
   .ID_BITS  (ID_BITS)
) u_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_ok              (rsp_ok),
   .rsp_served_id       (rsp_served_id),
   .rsp_found_preferred (rsp_found_preferred),
   .rsp_occupancy       (rsp_occupancy)
);

@@ tb/two_class_priority_queue_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_class_priority_queue_unit_tb
// Checks the two-class id queue against a behavioral copy of the queue kept
// in the bench. Each accepted request word updates the copy and queues the
// word the block should answer with; every answer is compared field by
// field. Directed cases, a fill to capacity, random traffic with idling on
// both channels, a long output stall and a final stretch at full rate.
// ----------------------------------------------------------------------------
module two_class_priority_queue_unit_tb;
   import tcpq_pkg::*;

   localparam int CAPACITY    = 32;
   localparam int ID_BITS     = 16;
   localparam int OCC_BITS    = $clog2(CAPACITY + 1);
   localparam int POOL_SIZE   = 48;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 4 * CAPACITY + 20;

   typedef struct packed {
      logic                ok;
      logic [ID_BITS-1:0]  served_id;
      logic                found_preferred;
      logic [OCC_BITS-1:0] occupancy;
   } queue_answer_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_kind = KIND_QUERY;
   logic [ID_BITS-1:0]  req_person_id = '0;
   logic                req_preferred = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_ok;
   logic [ID_BITS-1:0]  rsp_served_id;
   logic                rsp_found_preferred;
   logic [OCC_BITS-1:0] rsp_occupancy;

   // bench copy of the queue, slot 0 is the head
   logic [ID_BITS-1:0]  held_id [CAPACITY];
   logic                held_pref [CAPACITY];
   int                  n_held = 0;
   int                  n_pref = 0;

   queue_answer_type    pending_answers [$];
   logic [ID_BITS-1:0]  id_pool [POOL_SIZE];
   int                  error_count = 0;
   int                  quiet_cycles = 0;
   bit                  sender_idle = 1'b1;
   bit                  receiver_idle = 1'b1;
   int                  holds_asked = 0;
   int                  holds_taken = 0;
   int                  stall_left = 0;

   two_class_priority_queue_unit #(
      .CAPACITY (CAPACITY),
      .ID_BITS  (ID_BITS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_person_id       (req_person_id),
      .req_preferred       (req_preferred),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_ok              (rsp_ok),
      .rsp_served_id       (rsp_served_id),
      .rsp_found_preferred (rsp_found_preferred),
      .rsp_occupancy       (rsp_occupancy)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // slot of an id in the bench copy, n_held when absent
   function automatic int locate(input logic [ID_BITS-1:0] id);
      for (int i = 0; i < n_held; i++)
         if (held_id[i] == id)
            return i;
      return n_held;
   endfunction

   // close the gap left by a removed entry
   function automatic void drop_slot(input int pos);
      if (held_pref[pos])
         n_pref--;
      for (int i = pos; i + 1 < n_held; i++) begin
         held_id[i]   = held_id[i + 1];
         held_pref[i] = held_pref[i + 1];
      end
      n_held--;
   endfunction

   // apply one request to the bench copy and return the answer it gives
   function automatic queue_answer_type apply_request(input logic [1:0] kind,
                                                      input logic [ID_BITS-1:0] id,
                                                      input logic pref);
      queue_answer_type ans;
      int               pos;
      int               ipos;
      ans = '0;
      pos = locate(id);
      case (kind)
         KIND_INSERT: begin
            if (n_held < CAPACITY && pos == n_held) begin
               // preferential ids queue behind the last preferential entry
               ipos = pref ? n_pref : n_held;
               for (int i = n_held; i > ipos; i--) begin
                  held_id[i]   = held_id[i - 1];
                  held_pref[i] = held_pref[i - 1];
               end
               held_id[ipos]   = id;
               held_pref[ipos] = pref;
               n_held++;
               if (pref)
                  n_pref++;
               ans.ok = 1'b1;
            end
         end
         KIND_SERVE: begin
            if (n_held > 0) begin
               ans.served_id = held_id[0];
               drop_slot(0);
               ans.ok = 1'b1;
            end
         end
         KIND_WITHDRAW: begin
            if (pos < n_held) begin
               drop_slot(pos);
               ans.ok = 1'b1;
            end
         end
         default: begin
            if (pos < n_held) begin
               ans.ok              = 1'b1;
               ans.found_preferred = held_pref[pos];
            end
         end
      endcase
      ans.occupancy = OCC_BITS'(n_held);
      return ans;
   endfunction

   // mostly ids from a small pool or already held, sometimes any id
   function automatic logic [ID_BITS-1:0] pick_id();
      int r;
      r = $urandom_range(0, 3);
      if (r == 0 && n_held > 0)
         return held_id[$urandom_range(0, n_held - 1)];
      if (r == 3)
         return ID_BITS'($urandom_range(0, 65535));
      return id_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // an id not held at the moment
   function automatic logic [ID_BITS-1:0] fresh_id();
      logic [ID_BITS-1:0] id;
      id = ID_BITS'($urandom_range(0, 65535));
      while (locate(id) < n_held)
         id = ID_BITS'($urandom_range(0, 65535));
      return id;
   endfunction

   // offer one request word and wait until it is taken
   task automatic send_word(input logic [1:0] kind, input logic [ID_BITS-1:0] id,
                            input logic pref);
      int gap;
      if (sender_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_person_id <= id;
      req_preferred <= pref;
      do @(posedge clock); while (!req_ready);
      pending_answers.push_back(apply_request(kind, id, pref));
   endtask

   // one random request, insert share given in percent
   task automatic send_random_word(input int insert_pct);
      int         pick;
      int         span;
      logic [1:0] kind;
      pick = $urandom_range(0, 99);
      span = 100 - insert_pct;
      if (pick < insert_pct)
         kind = KIND_INSERT;
      else if (pick - insert_pct < span / 3)
         kind = KIND_SERVE;
      else if (pick - insert_pct < 2 * span / 3)
         kind = KIND_WITHDRAW;
      else
         kind = KIND_QUERY;
      send_word(kind, pick_id(), 1'($urandom_range(0, 1)));
   endtask

   // empty queue cases, id extremes, class order, duplicates, withdraws
   task automatic test_directed_cases();
      send_word(KIND_SERVE,    16'h0000, 1'b0);
      send_word(KIND_QUERY,    16'h1234, 1'b0);
      send_word(KIND_WITHDRAW, 16'h1234, 1'b1);
      send_word(KIND_INSERT,   16'h0000, 1'b0);
      send_word(KIND_INSERT,   16'hFFFF, 1'b1);
      send_word(KIND_INSERT,   16'h8000, 1'b0);
      send_word(KIND_INSERT,   16'h7FFF, 1'b1);
      send_word(KIND_INSERT,   16'h0000, 1'b1);
      send_word(KIND_INSERT,   16'hFFFF, 1'b0);
      send_word(KIND_QUERY,    16'hFFFF, 1'b0);
      send_word(KIND_QUERY,    16'h0000, 1'b1);
      send_word(KIND_QUERY,    16'h5555, 1'b1);
      send_word(KIND_WITHDRAW, 16'h7FFF, 1'b0);
      send_word(KIND_WITHDRAW, 16'h8000, 1'b0);
      send_word(KIND_INSERT,   16'hAAAA, 1'b1);
      send_word(KIND_SERVE,    16'h1234, 1'b0);
      send_word(KIND_SERVE,    16'h0000, 1'b0);
      send_word(KIND_SERVE,    16'hFFFF, 1'b1);
      send_word(KIND_SERVE,    16'h0000, 1'b0);
      send_word(KIND_QUERY,    16'h0000, 1'b1);
      send_word(KIND_WITHDRAW, 16'h0000, 1'b0);
   endtask

   // fill to capacity, inserts into a full queue, then drain to empty
   task automatic test_fill_to_capacity();
      logic [ID_BITS-1:0] id;
      while (n_held < CAPACITY)
         send_word(KIND_INSERT, fresh_id(), 1'($urandom_range(0, 1)));
      send_word(KIND_INSERT, fresh_id(), 1'b0);
      send_word(KIND_INSERT, fresh_id(), 1'b1);
      send_word(KIND_INSERT, held_id[0], 1'b0);
      send_word(KIND_QUERY, held_id[0], 1'b0);
      send_word(KIND_QUERY, held_id[CAPACITY - 1], 1'b1);
      // free the first ordinary slot and refill with a preferential id
      send_word(KIND_WITHDRAW, held_id[(n_pref < n_held) ? n_pref : 0], 1'b0);
      id = fresh_id();
      send_word(KIND_INSERT, id, 1'b1);
      send_word(KIND_QUERY, id, 1'b0);
      send_word(KIND_WITHDRAW, held_id[CAPACITY - 1], 1'b0);
      while (n_held > 0)
         send_word(KIND_SERVE, ID_BITS'($urandom_range(0, 65535)), 1'b1);
      send_word(KIND_SERVE, 16'hFFFF, 1'b1);
   endtask

   // random traffic in segments that push the depth up or down
   task automatic test_random_traffic(input int count);
      int seg_left;
      int insert_pct;
      seg_left   = 0;
      insert_pct = 45;
      for (int n = 0; n < count; n++) begin
         if (seg_left == 0) begin
            case ($urandom_range(0, 2))
               0: insert_pct = 20;
               1: insert_pct = 45;
               default: insert_pct = 75;
            endcase
            seg_left = $urandom_range(20, 80);
         end
         seg_left--;
         send_random_word(insert_pct);
      end
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_output_backpressure(input int count);
      sender_idle = 1'b0;
      holds_asked++;
      for (int n = 0; n < count; n++)
         send_random_word(50);
      sender_idle = 1'b1;
   endtask

   // last stretch at full rate on both sides
   task automatic test_back_to_back(input int count);
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      for (int n = 0; n < count; n++)
         send_random_word(45);
   endtask

   // receiver: random stall bursts plus the requested long hold
   always @(negedge clock) begin
      if (holds_taken != holds_asked) begin
         holds_taken = holds_taken + 1;
         stall_left  = HOLD_CYCLES;
      end else if (stall_left == 0 && receiver_idle && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each answer word with the oldest expected one
   always @(posedge clock) begin
      queue_answer_type got;
      queue_answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_ok, rsp_served_id, rsp_found_preferred, rsp_occupancy};
         if (pending_answers.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: unexpected answer word ok=%0b id=%h pref=%0b occ=%0d",
                        $realtime, got.ok, got.served_id, got.found_preferred,
                        got.occupancy);
         end else begin
            want = pending_answers.pop_front();
            if (got.ok !== want.ok || got.served_id !== want.served_id ||
                got.found_preferred !== want.found_preferred ||
                got.occupancy !== want.occupancy) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: answer mismatch: expected ok=%0b id=%h pref=%0b occ=%0d",
                           $realtime, want.ok, want.served_id, want.found_preferred,
                           want.occupancy);
                  $display("%0t: answer mismatch: got      ok=%0b id=%h pref=%0b occ=%0d",
                           $realtime, got.ok, got.served_id, got.found_preferred,
                           got.occupancy);
               end
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // test sequence
   initial begin
      for (int i = 0; i < POOL_SIZE; i++)
         id_pool[i] = ID_BITS'($urandom_range(0, 65535));
      id_pool[0] = '0;
      id_pool[1] = '1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_fill_to_capacity();
      test_random_traffic(840);
      test_output_backpressure(40);
      test_back_to_back(150);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && pending_answers.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
